// ----- rtl/core/rneu_pkg.sv -----
// Shared types, constants and helper functions for the reaction network Euler step unit.
// No dependencies; every other file imports this package.
`default_nettype none

package rneu_pkg;

   localparam int DEF_PULSE_SLOTS = 8;
   localparam int DEF_STEP_LIMIT  = 1000000;

   localparam int LEVEL_W     = 48;
   localparam int RATE_W      = 32;
   localparam int TIME_W      = 20;
   localparam int SPECIES_W   = 3;
   localparam int SLOT_FLD_W  = 3;
   localparam int OP_W        = 2;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_SPECIES = 6;
   localparam int NUM_RATES   = 5;
   localparam int MUL_COUNT   = 8;
   localparam int MUL_K_W     = 3;
   localparam int PART_W      = 2;
   localparam int ACC_W       = 96;

   localparam logic [OP_W-1:0] OP_ADVANCE    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_LEVEL = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_PULSE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_BIND_B    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_UNBIND_B  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_BIND_C    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_UNBIND_C  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_CONSUME_L = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TOL     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_COUNT    = 3'd6;

   localparam logic [RATE_W-1:0] SETTLE_TOL_RESET = 32'd42950;

   localparam logic [SPECIES_W-1:0] SP_L = 3'd0;
   localparam logic [SPECIES_W-1:0] SP_R = 3'd1;
   localparam logic [SPECIES_W-1:0] SP_B = 3'd2;
   localparam logic [SPECIES_W-1:0] SP_D = 3'd3;
   localparam logic [SPECIES_W-1:0] SP_C = 3'd4;
   localparam logic [SPECIES_W-1:0] SP_X = 3'd5;

   typedef logic signed [LEVEL_W-1:0] level_type;

   localparam level_type LEVEL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam level_type LEVEL_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [SPECIES_W-1:0]     species_index;
      logic [SLOT_FLD_W-1:0]    pulse_slot;
      logic signed [LEVEL_W-1:0] amount;
      logic [TIME_W-1:0]        window_start;
      logic [TIME_W-1:0]        window_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level_l;
      logic signed [LEVEL_W-1:0] level_r;
      logic signed [LEVEL_W-1:0] level_b;
      logic signed [LEVEL_W-1:0] level_d;
      logic signed [LEVEL_W-1:0] level_c;
      logic signed [LEVEL_W-1:0] level_x;
      logic [TIME_W-1:0]        step_time;
      logic                     at_equilibrium;
      logic                     limit_reached;
   } rsp_payload_type;

   typedef struct packed {
      logic [SPECIES_W-1:0]      target;
      logic signed [LEVEL_W-1:0] add;
      logic [TIME_W-1:0]         wstart;
      logic [TIME_W-1:0]         wend;
   } pulse_entry_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_BEGIN,
      CMD_EXEC,
      CMD_MLOAD,
      CMD_MPART,
      CMD_MFIN,
      CMD_STOICH,
      CMD_PREAD,
      CMD_PAPPLY,
      CMD_SETTLE,
      CMD_OUTPUT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [MUL_K_W-1:0] mul_k;
      logic [PART_W-1:0]  part;
   } dp_cmd_type;

   typedef struct packed {
      logic advance;
      logic flag_set;
      logic pulse_more;
   } dp_status_type;

   // Multiply schedule: k walks L*R, B, L*D, C, L*X chains in reaction order.
   function automatic logic mul_first(input logic [MUL_K_W-1:0] k);
      return k inside {3'd0, 3'd2, 3'd3, 3'd5, 3'd6};
   endfunction

   function automatic logic mul_last(input logic [MUL_K_W-1:0] k);
      return k inside {3'd1, 3'd2, 3'd4, 3'd5, 3'd7};
   endfunction

   function automatic logic [2:0] mul_rxn(input logic [MUL_K_W-1:0] k);
      case (k)
         3'd0, 3'd1: return 3'd0;
         3'd2:       return 3'd1;
         3'd3, 3'd4: return 3'd2;
         3'd5:       return 3'd3;
         default:    return 3'd4;
      endcase
   endfunction

   function automatic logic [SPECIES_W-1:0] mul_species(input logic [MUL_K_W-1:0] k);
      case (k)
         3'd0, 3'd3, 3'd6: return SP_L;
         3'd1:             return SP_R;
         3'd2:             return SP_B;
         3'd4:             return SP_D;
         3'd5:             return SP_C;
         default:          return SP_X;
      endcase
   endfunction

   // Stoichiometric coefficient: 2'b01 is +1, 2'b11 is -1, zero otherwise.
   function automatic logic [1:0] stoich(input logic [2:0] rxn, input logic [SPECIES_W-1:0] sp);
      case (rxn)
         3'd0: begin
            if (sp == SP_L || sp == SP_R) return 2'b11;
            else if (sp == SP_B) return 2'b01;
            else return 2'b00;
         end
         3'd1: begin
            if (sp == SP_L || sp == SP_R) return 2'b01;
            else if (sp == SP_B) return 2'b11;
            else return 2'b00;
         end
         3'd2: begin
            if (sp == SP_L || sp == SP_D) return 2'b11;
            else if (sp == SP_C) return 2'b01;
            else return 2'b00;
         end
         3'd3: begin
            if (sp == SP_L || sp == SP_D) return 2'b01;
            else if (sp == SP_C) return 2'b11;
            else return 2'b00;
         end
         default: begin
            if (sp == SP_L) return 2'b11;
            else return 2'b00;
         end
      endcase
   endfunction

   function automatic level_type sat48(input logic signed [LEVEL_W+1:0] v);
      if (v[LEVEL_W+1:LEVEL_W-1] == 3'b000 || v[LEVEL_W+1:LEVEL_W-1] == 3'b111) begin
         return v[LEVEL_W-1:0];
      end else if (v[LEVEL_W+1]) begin
         return LEVEL_MIN;
      end else begin
         return LEVEL_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rneu_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on rneu_pkg for the payload types.
`default_nettype none

interface rneu_req_if;
   import rneu_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rneu_rsp_if;
   import rneu_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rneu_ctrl.sv -----
// Sequencer for the Euler step unit: handshakes and the per-step command schedule.
// Depends on rneu_pkg; drives rneu_dpath through dp_cmd_type.
`default_nettype none

module rneu_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rneu_pkg::dp_status_type status,
   output rneu_pkg::dp_cmd_type         cmd
);
   import rneu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EXEC,
      ST_MLOAD,
      ST_MPART,
      ST_MFIN,
      ST_STOICH,
      ST_PNEXT,
      ST_PREAD,
      ST_PAPPLY,
      ST_SETTLE,
      ST_OUT
   } state_type;

   state_type          state_ff;
   logic [MUL_K_W-1:0] mul_k_ff;
   logic [PART_W-1:0]  part_ff;
   logic               rsp_valid_ff;
   logic               out_go;

   assign out_go    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_k_ff     <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_DISPATCH;
            end
            ST_DISPATCH: begin
               if (!status.advance) begin
                  state_ff <= ST_EXEC;
               end else if (status.flag_set) begin
                  state_ff <= ST_OUT;
               end else begin
                  mul_k_ff <= '0;
                  state_ff <= ST_MLOAD;
               end
            end
            ST_EXEC: state_ff <= ST_OUT;
            ST_MLOAD: begin
               part_ff  <= '0;
               state_ff <= ST_MPART;
            end
            ST_MPART: begin
               part_ff <= part_ff + 1'b1;
               if (part_ff == 2'd3) state_ff <= ST_MFIN;
            end
            ST_MFIN: begin
               if (mul_last(mul_k_ff)) begin
                  state_ff <= ST_STOICH;
               end else begin
                  mul_k_ff <= mul_k_ff + 1'b1;
                  state_ff <= ST_MLOAD;
               end
            end
            ST_STOICH: begin
               if (mul_k_ff == MUL_K_W'(MUL_COUNT - 1)) begin
                  state_ff <= ST_PNEXT;
               end else begin
                  mul_k_ff <= mul_k_ff + 1'b1;
                  state_ff <= ST_MLOAD;
               end
            end
            ST_PNEXT:  state_ff <= status.pulse_more ? ST_PREAD : ST_SETTLE;
            ST_PREAD:  state_ff <= ST_PAPPLY;
            ST_PAPPLY: state_ff <= ST_PNEXT;
            ST_SETTLE: state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_go) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.mul_k = mul_k_ff;
      cmd.part  = part_ff;
      case (state_ff)
         ST_IDLE:     cmd.kind = CMD_CAPTURE;
         ST_DISPATCH: cmd.kind = CMD_BEGIN;
         ST_EXEC:     cmd.kind = CMD_EXEC;
         ST_MLOAD:    cmd.kind = CMD_MLOAD;
         ST_MPART:    cmd.kind = CMD_MPART;
         ST_MFIN:     cmd.kind = CMD_MFIN;
         ST_STOICH:   cmd.kind = CMD_STOICH;
         ST_PREAD:    cmd.kind = CMD_PREAD;
         ST_PAPPLY:   cmd.kind = CMD_PAPPLY;
         ST_SETTLE:   cmd.kind = CMD_SETTLE;
         ST_OUT:      cmd.kind = out_go ? CMD_OUTPUT : CMD_NONE;
         default:     cmd.kind = CMD_NONE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted word did not reach dispatch");

   a_mfin_after_parts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MFIN) |-> ($past(part_ff) == 2'd3))
      else $error("multiply finished before all partial products");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside output state");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREAD) |-> status.pulse_more)
      else $error("pulse read past active slots");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rneu_dpath.sv -----
// Datapath: levels, pulse memory, shared 24x24 multiplier, stoichiometry and settle check.
// Depends on rneu_pkg; commanded by rneu_ctrl.
`default_nettype none

module rneu_dpath #(
   parameter int PULSE_SLOTS = rneu_pkg::DEF_PULSE_SLOTS,
   parameter int STEP_LIMIT  = rneu_pkg::DEF_STEP_LIMIT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [rneu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rneu_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire rneu_pkg::req_payload_type            req_payload,
   input  wire rneu_pkg::dp_cmd_type                 cmd,
   output rneu_pkg::dp_status_type                   status,
   output rneu_pkg::rsp_payload_type                 rsp_payload
);
   import rneu_pkg::*;

   localparam int SLOT_W     = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
   localparam int SLOT_CNT_W = $clog2(PULSE_SLOTS + 1);

   logic [RATE_W-1:0]  rate_ff [NUM_RATES];
   logic [RATE_W-1:0]  tol_ff;
   logic [COUNT_W-1:0] pcount_ff;

   level_type lev_ff  [NUM_SPECIES];
   level_type prev_ff [NUM_SPECIES];
   logic [TIME_W-1:0] time_ff;
   logic              settled_ff;
   logic              exhausted_ff;

   req_payload_type   req_ff;
   rsp_payload_type   out_ff;

   pulse_entry_type   pmem [PULSE_SLOTS];
   logic [PULSE_SLOTS-1:0] pvalid_ff;
   pulse_entry_type   rd_ff;
   logic              rd_valid_ff;
   logic [SLOT_CNT_W-1:0] slot_ff;

   logic [LEVEL_W-1:0] ux_ff, uy_ff;
   logic               neg_ff;
   logic [ACC_W-1:0]   acc_ff;
   level_type          prod_ff;

   // combinational helpers
   logic [2:0]          rxn;
   level_type           x_src, y_src;
   logic [LEVEL_W-1:0]  x_mag, y_mag;
   logic [23:0]         a_half, b_half;
   logic [LEVEL_W-1:0]  pp;
   logic [ACC_W-1:0]    pp_sh;
   logic [63:0]         q;
   logic                rem;
   logic [64:0]         mag;
   level_type           prod_in;
   level_type           stoich_lev [NUM_SPECIES];
   level_type           pulse_lev  [NUM_SPECIES];
   logic [TIME_W:0]     step_a;
   logic                hit;
   logic                eq;
   logic [TIME_W-1:0]   time_in;
   logic                exhaust_in;
   logic                slot_ok;
   logic                load_ok;

   // rate terms always use the levels from before the step
   assign rxn    = mul_rxn(cmd.mul_k);
   assign x_src  = mul_first(cmd.mul_k) ? level_type'({16'b0, rate_ff[rxn]}) : prod_ff;
   assign y_src  = prev_ff[mul_species(cmd.mul_k)];
   assign x_mag  = x_src[LEVEL_W-1] ? LEVEL_W'(-x_src) : LEVEL_W'(x_src);
   assign y_mag  = y_src[LEVEL_W-1] ? LEVEL_W'(-y_src) : LEVEL_W'(y_src);

   assign a_half = cmd.part[0] ? ux_ff[47:24] : ux_ff[23:0];
   assign b_half = cmd.part[1] ? uy_ff[47:24] : uy_ff[23:0];
   assign pp     = a_half * b_half;

   always_comb begin
      case (cmd.part)
         2'd0:    pp_sh = {48'b0, pp};
         2'd3:    pp_sh = {pp, 48'b0};
         default: pp_sh = {24'b0, pp, 24'b0};
      endcase
   end

   // floor(x*y / 2^32), rounded toward minus infinity, with sign and saturation
   assign q   = acc_ff[ACC_W-1:32];
   assign rem = |acc_ff[31:0];
   assign mag = {1'b0, q} + 65'(rem);

   always_comb begin
      if (!neg_ff) begin
         prod_in = (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : level_type'(q[LEVEL_W-1:0]);
      end else begin
         prod_in = (mag > 65'h8000_0000_0000) ? LEVEL_MIN
                                              : level_type'(-mag[LEVEL_W-1:0]);
      end
   end

   always_comb begin
      logic [1:0]                s;
      logic signed [LEVEL_W+1:0] amt_x;
      logic signed [LEVEL_W+1:0] delta;
      amt_x = (LEVEL_W+2)'(prod_ff);
      for (int c = 0; c < NUM_SPECIES; c++) begin
         s = stoich(rxn, SPECIES_W'(c));
         if (s == 2'b01) delta = amt_x;
         else if (s == 2'b11) delta = -amt_x;
         else delta = '0;
         stoich_lev[c] = sat48((LEVEL_W+2)'(lev_ff[c]) + delta);
      end
   end

   assign step_a = {1'b0, time_ff} + 1'b1;
   assign hit    = rd_valid_ff && (rd_ff.target < SPECIES_W'(NUM_SPECIES))
                   && ((TIME_W+1)'(rd_ff.wstart) <= step_a)
                   && (step_a < (TIME_W+1)'(rd_ff.wend));

   always_comb begin
      level_type psum;
      for (int c = 0; c < NUM_SPECIES; c++) begin
         psum = sat48((LEVEL_W+2)'(lev_ff[c]) + (LEVEL_W+2)'(rd_ff.add));
         if (hit && rd_ff.target == SPECIES_W'(c)) begin
            pulse_lev[c] = psum[LEVEL_W-1] ? '0 : psum;
         end else begin
            pulse_lev[c] = lev_ff[c];
         end
      end
   end

   always_comb begin
      logic signed [LEVEL_W:0] d;
      logic [LEVEL_W:0]        ad;
      eq = 1'b1;
      for (int c = 0; c < NUM_SPECIES; c++) begin
         d  = (LEVEL_W+1)'(lev_ff[c]) - (LEVEL_W+1)'(prev_ff[c]);
         ad = d[LEVEL_W] ? (LEVEL_W+1)'(-d) : (LEVEL_W+1)'(d);
         if (ad >= (LEVEL_W+1)'(tol_ff)) eq = 1'b0;
      end
   end

   assign time_in    = step_a[TIME_W-1:0];
   assign exhaust_in = (32'(time_in) >= 32'(STEP_LIMIT - 1));
   assign slot_ok    = 32'(req_ff.pulse_slot) < 32'(PULSE_SLOTS);
   assign load_ok    = req_ff.species_index < SPECIES_W'(NUM_SPECIES);

   assign status.advance    = (req_ff.op == OP_ADVANCE);
   assign status.flag_set   = settled_ff || exhausted_ff;
   assign status.pulse_more = (32'(slot_ff) < 32'(pcount_ff))
                              && (32'(slot_ff) < 32'(PULSE_SLOTS));
   assign rsp_payload = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_RATES; r++) rate_ff[r] <= '0;
         tol_ff    <= SETTLE_TOL_RESET;
         pcount_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE_BIND_B, CSR_RATE_UNBIND_B, CSR_RATE_BIND_C,
            CSR_RATE_UNBIND_C, CSR_RATE_CONSUME_L: rate_ff[csr_index] <= csr_wdata;
            CSR_SETTLE_TOL:  tol_ff    <= csr_wdata;
            CSR_PULSE_COUNT: pcount_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pulse table: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.kind == CMD_EXEC && req_ff.op == OP_LOAD_PULSE && slot_ok) begin
         pmem[SLOT_W'(req_ff.pulse_slot)] <= '{target: req_ff.species_index,
                                               add:    req_ff.amount,
                                               wstart: req_ff.window_start,
                                               wend:   req_ff.window_end};
      end
      if (cmd.kind == CMD_PREAD) begin
         rd_ff <= pmem[slot_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.kind == CMD_EXEC && req_ff.op == OP_LOAD_PULSE && slot_ok) begin
            pvalid_ff[SLOT_W'(req_ff.pulse_slot)] <= 1'b1;
         end
         if (cmd.kind == CMD_PREAD) begin
            rd_valid_ff <= pvalid_ff[slot_ff[SLOT_W-1:0]];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.kind)
         CMD_CAPTURE: req_ff <= req_payload;
         CMD_BEGIN: begin
            for (int c = 0; c < NUM_SPECIES; c++) prev_ff[c] <= lev_ff[c];
         end
         CMD_MLOAD: begin
            ux_ff  <= x_mag;
            uy_ff  <= y_mag;
            neg_ff <= x_src[LEVEL_W-1] ^ y_src[LEVEL_W-1];
            acc_ff <= '0;
         end
         CMD_MPART: acc_ff  <= acc_ff + pp_sh;
         CMD_MFIN:  prod_ff <= prod_in;
         CMD_OUTPUT: begin
            out_ff.level_l        <= lev_ff[SP_L];
            out_ff.level_r        <= lev_ff[SP_R];
            out_ff.level_b        <= lev_ff[SP_B];
            out_ff.level_d        <= lev_ff[SP_D];
            out_ff.level_c        <= lev_ff[SP_C];
            out_ff.level_x        <= lev_ff[SP_X];
            out_ff.step_time      <= time_ff;
            out_ff.at_equilibrium <= settled_ff;
            out_ff.limit_reached  <= exhausted_ff;
         end
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_SPECIES; c++) lev_ff[c] <= '0;
         time_ff      <= '0;
         settled_ff   <= 1'b0;
         exhausted_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         case (cmd.kind)
            CMD_BEGIN: slot_ff <= '0;
            CMD_EXEC: begin
               if (req_ff.op == OP_LOAD_LEVEL && load_ok) begin
                  for (int c = 0; c < NUM_SPECIES; c++) begin
                     if (req_ff.species_index == SPECIES_W'(c)) lev_ff[c] <= req_ff.amount;
                  end
                  time_ff      <= '0;
                  settled_ff   <= 1'b0;
                  exhausted_ff <= 1'b0;
               end
            end
            CMD_STOICH: begin
               for (int c = 0; c < NUM_SPECIES; c++) lev_ff[c] <= stoich_lev[c];
            end
            CMD_PAPPLY: begin
               for (int c = 0; c < NUM_SPECIES; c++) lev_ff[c] <= pulse_lev[c];
               slot_ff <= slot_ff + 1'b1;
            end
            CMD_SETTLE: begin
               time_ff <= time_in;
               if (eq) settled_ff <= 1'b1;
               if (exhaust_in) exhausted_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_settle_source: assert property (@(posedge clock) disable iff (reset)
      $rose(settled_ff) |-> ($past(cmd.kind) == CMD_SETTLE))
      else $error("equilibrium flag set outside settle");

   a_time_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(time_ff))
         |-> ($past(cmd.kind) == CMD_SETTLE || $past(cmd.kind) == CMD_EXEC))
      else $error("step time changed outside settle or load");

   a_no_mul_when_flagged: assert property (@(posedge clock) disable iff (reset)
      (cmd.kind == CMD_MLOAD || cmd.kind == CMD_MPART || cmd.kind == CMD_MFIN)
         |-> !(settled_ff || exhausted_ff))
      else $error("step running while a stop flag is set");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/reaction_network_euler_step_unit.sv -----
// Top level of the reaction network Euler step unit: sequencer plus datapath.
// Depends on rneu_pkg, rneu_if, rneu_ctrl and rneu_dpath.
//
//   channel  dir  handshake      word
//   req_ch   in   valid/ready    op, species_index, pulse_slot, amount, window_start/end
//   rsp_ch   out  valid/ready    six levels, step_time, at_equilibrium, limit_reached
//   csr_*    in   csr_we only    csr_index, csr_wdata
//
// Level and pulse loads pass through dispatch, execute and output before the response.
// An advance runs eight multiplies on one shared 24x24 multiplier (load, partial
// products, finish), five stoichiometry updates, and a test, read and apply for each
// active pulse slot.
// An advance with a stop flag set goes from dispatch straight to the output state.
// Reset is synchronous; one word is in flight, and a stalled response holds the next
// result in the output state and keeps the request side blocked.
`default_nettype none

module reaction_network_euler_step_unit #(
   parameter int PULSE_SLOTS = rneu_pkg::DEF_PULSE_SLOTS,
   parameter int STEP_LIMIT  = rneu_pkg::DEF_STEP_LIMIT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rneu_req_if.sink                                req_ch,
   rneu_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [rneu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rneu_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rneu_pkg::*;

   dp_cmd_type      cmd;
   dp_status_type   status;
   rsp_payload_type rsp_word;

   rneu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rneu_dpath #(
      .PULSE_SLOTS (PULSE_SLOTS),
      .STEP_LIMIT  (STEP_LIMIT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_ch.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_word)
   );

   assign rsp_ch.payload = rsp_word;

endmodule

`default_nettype wire
